// File: rtl/pts_pkg.sv
// shared types, codes and constants for the periodic timer scheduler
package pts_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int TIME_W      = 48;
    localparam int HANDLE_W    = 32;
    localparam int TICKS_W     = 32;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;

    localparam logic [1:0] EV_SCHEDULED = 2'd0;
    localparam logic [1:0] EV_CANCEL    = 2'd1;
    localparam logic [1:0] EV_FIRED     = 2'd2;
    localparam logic [1:0] EV_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]          command;
        logic [TICKS_W-1:0]  delay_ticks;
        logic [TICKS_W-1:0]  period_ticks;
        logic [HANDLE_W-1:0] cancel_handle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          event_kind;
        logic [HANDLE_W-1:0] timer_handle;
        logic                found;
        logic                last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUE,
        ST_PICK,
        ST_FIRE,
        ST_SCHED,
        ST_CAN,
        ST_CAN_REPLY
    } state_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_DUE,
        DP_PICK,
        DP_FIRE,
        DP_SCHED,
        DP_CAN_STEP,
        DP_CAN_EMIT
    } dp_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic any_due;
        logic fire_last;
        logic can_hit;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/periodic_timer_scheduler.sv
// top level of the periodic timer scheduler
//
//   channel   ports                      carries
//   s_        s_valid s_ready s_data     one request: tick, schedule or cancel
//   m_        m_valid m_ready m_data     result events, last marks the final one
//
// a tick scans the table once to mark due timers and once more per fired timer;
// every scan walks the slot table one entry per cycle.
// a quiet tick ends with no result.
// synchronous active-low reset empties the table and zeroes time and handle counter.
// a stalled m_ready holds the current result and the scan waits before the next one.
module periodic_timer_scheduler #(
    parameter int TIMER_SLOTS = pts_pkg::TIMER_SLOTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pts_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pts_pkg::out_item_t m_data
);
    pts_pkg::dp_cmd_t    cmd;
    pts_pkg::dp_status_t status;

    pts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .command (s_data.command),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pts_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/pts_datapath.sv
// slot table, scan registers and result register of the timer scheduler
module pts_datapath #(
    parameter int TIMER_SLOTS = pts_pkg::TIMER_SLOTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pts_pkg::in_item_t    s_data,
    input  pts_pkg::dp_cmd_t     cmd,
    output pts_pkg::dp_status_t  status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pts_pkg::out_item_t   m_data
);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int TW = pts_pkg::TIME_W;
    localparam int HW = pts_pkg::HANDLE_W;
    localparam int PW = pts_pkg::TICKS_W;
    localparam int CW = pts_pkg::FIRE_CNT_W;

    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [TIMER_SLOTS-1:0] due_reg, due_next;
    logic [HW-1:0]          handle_reg [TIMER_SLOTS];
    logic [TW-1:0]          wake_reg   [TIMER_SLOTS];
    logic [PW-1:0]          period_reg [TIMER_SLOTS];

    logic [TW-1:0]          time_reg;
    logic [HW-1:0]          next_handle_reg;
    pts_pkg::in_item_t      in_reg;
    logic [IW-1:0]          idx_reg;
    logic                   best_valid_reg;
    logic [IW-1:0]          best_idx_reg;
    logic [TW-1:0]          best_wake_reg;
    logic [HW-1:0]          best_handle_reg;
    logic [CW-1:0]          fire_cnt_reg;
    logic                   found_reg;
    logic                   m_valid_reg;
    pts_pkg::out_item_t     m_data_reg;

    logic                   free_found;
    logic [IW-1:0]          free_idx;
    logic                   idx_last;
    logic [IW-1:0]          idx_step;
    logic                   earlier;
    logic [TIMER_SLOTS-1:0] due_left;
    logic                   fire_last;
    logic                   can_hit;
    logic [PW-1:0]          fire_period;

    assign idx_last = (idx_reg == IW'(TIMER_SLOTS - 1));
    assign idx_step = idx_last ? '0 : idx_reg + 1'b1;
    assign can_hit  = valid_reg[idx_reg] && (handle_reg[idx_reg] == in_reg.cancel_handle);
    assign fire_period = period_reg[best_idx_reg];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // wake time first, then handle; equal keeps the lower slot seen first
    always_comb begin
        if (wake_reg[idx_reg] != best_wake_reg) begin
            earlier = wake_reg[idx_reg] < best_wake_reg;
        end else begin
            earlier = handle_reg[idx_reg] < best_handle_reg;
        end
    end

    always_comb begin
        due_left               = due_reg;
        due_left[best_idx_reg] = 1'b0;
    end

    assign fire_last = (fire_cnt_reg == CW'(pts_pkg::MAX_RESULTS - 1)) || (due_left == '0);

    always_comb begin
        valid_next = valid_reg;
        due_next   = due_reg;
        case (cmd)
            pts_pkg::DP_DUE: begin
                due_next[idx_reg] = valid_reg[idx_reg] && (time_reg > wake_reg[idx_reg]);
            end
            pts_pkg::DP_FIRE: begin
                due_next = due_left;
                if (fire_period == '0) begin
                    valid_next[best_idx_reg] = 1'b0;
                end
            end
            pts_pkg::DP_SCHED: begin
                if (free_found) begin
                    valid_next[free_idx] = 1'b1;
                end
            end
            pts_pkg::DP_CAN_STEP: begin
                if (can_hit) begin
                    valid_next[idx_reg] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            due_reg         <= '0;
            time_reg        <= '0;
            next_handle_reg <= '0;
            idx_reg         <= '0;
            best_valid_reg  <= 1'b0;
            fire_cnt_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            due_reg   <= due_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd)
                pts_pkg::DP_LOAD: begin
                    idx_reg        <= '0;
                    best_valid_reg <= 1'b0;
                    fire_cnt_reg   <= '0;
                    if (s_data.command == pts_pkg::CMD_TICK) begin
                        time_reg <= time_reg + 1'b1;
                    end
                end
                pts_pkg::DP_DUE: begin
                    idx_reg <= idx_step;
                end
                pts_pkg::DP_PICK: begin
                    idx_reg <= idx_step;
                    if (due_reg[idx_reg] && (!best_valid_reg || earlier)) begin
                        best_valid_reg <= 1'b1;
                    end
                end
                pts_pkg::DP_FIRE: begin
                    idx_reg        <= '0;
                    best_valid_reg <= 1'b0;
                    fire_cnt_reg   <= fire_cnt_reg + 1'b1;
                    m_valid_reg    <= 1'b1;
                end
                pts_pkg::DP_SCHED: begin
                    m_valid_reg <= 1'b1;
                    if (free_found) begin
                        next_handle_reg <= next_handle_reg + 1'b1;
                    end
                end
                pts_pkg::DP_CAN_STEP: begin
                    idx_reg <= idx_step;
                end
                pts_pkg::DP_CAN_EMIT: begin
                    m_valid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd)
            pts_pkg::DP_LOAD: begin
                in_reg <= s_data;
            end
            pts_pkg::DP_PICK: begin
                if (due_reg[idx_reg] && (!best_valid_reg || earlier)) begin
                    best_idx_reg    <= idx_reg;
                    best_wake_reg   <= wake_reg[idx_reg];
                    best_handle_reg <= handle_reg[idx_reg];
                end
            end
            pts_pkg::DP_FIRE: begin
                if (fire_period != '0) begin
                    wake_reg[best_idx_reg] <= best_wake_reg + TW'(fire_period);
                end
                m_data_reg.event_kind   <= pts_pkg::EV_FIRED;
                m_data_reg.timer_handle <= best_handle_reg;
                m_data_reg.found        <= 1'b0;
                m_data_reg.last         <= fire_last;
            end
            pts_pkg::DP_SCHED: begin
                if (free_found) begin
                    handle_reg[free_idx]    <= next_handle_reg;
                    wake_reg[free_idx]      <= time_reg + TW'(in_reg.delay_ticks);
                    period_reg[free_idx]    <= in_reg.period_ticks;
                    m_data_reg.event_kind   <= pts_pkg::EV_SCHEDULED;
                    m_data_reg.timer_handle <= next_handle_reg;
                end else begin
                    m_data_reg.event_kind   <= pts_pkg::EV_FULL;
                    m_data_reg.timer_handle <= '0;
                end
                m_data_reg.found <= 1'b0;
                m_data_reg.last  <= 1'b1;
            end
            pts_pkg::DP_CAN_STEP: begin
                found_reg <= can_hit;
            end
            pts_pkg::DP_CAN_EMIT: begin
                m_data_reg.event_kind   <= pts_pkg::EV_CANCEL;
                m_data_reg.timer_handle <= in_reg.cancel_handle;
                m_data_reg.found        <= found_reg;
                m_data_reg.last         <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign status.idx_last  = idx_last;
    assign status.any_due   = (due_reg != '0);
    assign status.fire_last = fire_last;
    assign status.can_hit   = can_hit;
    assign status.out_free  = !m_valid_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/pts_ctrl.sv
// controller state machine sequencing the slot scans of the timer scheduler
module pts_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          command,
    output logic                s_ready,
    input  pts_pkg::dp_status_t status,
    output pts_pkg::dp_cmd_t    cmd
);
    pts_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = pts_pkg::DP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            pts_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd = pts_pkg::DP_LOAD;
                    case (command)
                        pts_pkg::CMD_TICK:     state_next = pts_pkg::ST_DUE;
                        pts_pkg::CMD_SCHEDULE: state_next = pts_pkg::ST_SCHED;
                        pts_pkg::CMD_CANCEL:   state_next = pts_pkg::ST_CAN;
                        default:               state_next = pts_pkg::ST_IDLE;
                    endcase
                end
            end
            pts_pkg::ST_DUE: begin
                cmd = pts_pkg::DP_DUE;
                if (status.idx_last) begin
                    state_next = pts_pkg::ST_PICK;
                end
            end
            pts_pkg::ST_PICK: begin
                if (!status.any_due) begin
                    state_next = pts_pkg::ST_IDLE;
                end else begin
                    cmd = pts_pkg::DP_PICK;
                    if (status.idx_last) begin
                        state_next = pts_pkg::ST_FIRE;
                    end
                end
            end
            pts_pkg::ST_FIRE: begin
                if (status.out_free) begin
                    cmd        = pts_pkg::DP_FIRE;
                    state_next = status.fire_last ? pts_pkg::ST_IDLE : pts_pkg::ST_PICK;
                end
            end
            pts_pkg::ST_SCHED: begin
                if (status.out_free) begin
                    cmd        = pts_pkg::DP_SCHED;
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            pts_pkg::ST_CAN: begin
                cmd = pts_pkg::DP_CAN_STEP;
                if (status.can_hit || status.idx_last) begin
                    state_next = pts_pkg::ST_CAN_REPLY;
                end
            end
            pts_pkg::ST_CAN_REPLY: begin
                if (status.out_free) begin
                    cmd        = pts_pkg::DP_CAN_EMIT;
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
